// ===== design/bitmap_slot_allocator_assert.svh =====
// assertion macros used by the allocator sequencer
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bsa_pkg.sv =====
// types and constants shared by the bitmap slot allocator
package bsa_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam int OP_W   = 2;
  localparam int ELEM_W = 17;
  localparam int FIRST_W = 16;
  localparam int COUNT_W = 11;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic [FIRST_W-1:0] FIRST_RESET = 16'd0;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY  = 2'd0,
    OP_OCCUPY = 2'd1,
    OP_ALLOC  = 2'd2,
    OP_FREE   = 2'd3
  } op_t;

  typedef struct packed {
    logic             access;
    op_t              op;
    logic [BIT_W-1:0] acc_bit;
    logic             inject;
    logic [BIT_W-1:0] start_bit;
    logic [BIT_W-1:0] last_bit;
  } cell_ctl_t;

  typedef struct packed {
    logic             found;
    logic             fail;
    logic             rd_busy;
    logic [BIT_W-1:0] hit_bit;
  } cell_rsp_t;

endpackage

// ===== design/bitmap_slot_allocator.sv =====
// top level: config registers, cell chain and result reduction
//
// Next-fit bitmap allocator over element numbers first_element .. first_element
// + min(slot_count, MAX_SLOTS) - 1. A request (in_operation, in_element) is
// taken when start is high and busy is low; its single result (out_ok,
// out_granted_element) shows for one cycle with out_valid high and cannot be
// held off by the receiver. Query, occupy and free: the chain is accessed in
// the EXEC state and the result beat is registered from it. Allocate: a search
// token launched at the cursor's word makes h = 0 .. W hops along the cell
// chain to the word holding a free slot, W the number of 32-slot words in use;
// a full map fails after W hops; a slot count of zero fails with no search.
// busy falls with the result beat, so the next request may start in that cycle.
// Configuration goes through the APB port: first_element at 0x0, slot_count at
// 0x4; the user must write them only while busy is low, which the block itself
// does not enforce. Reset clears every busy bit, puts the cursor on the first
// slot and loads first_element 0 and slot_count 1024.
module bitmap_slot_allocator #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [bsa_pkg::OP_W-1:0]    in_operation,
  input  logic [bsa_pkg::ELEM_W-1:0]  in_element,
  output logic                        out_valid,
  output logic                        out_ok,
  output logic [bsa_pkg::ELEM_W-1:0]  out_granted_element,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsa_pkg::ADDR_W-1:0]  paddr,
  input  logic [bsa_pkg::DATA_W-1:0]  pwdata,
  output logic [bsa_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bsa_pkg::*;

  localparam int NCELLS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

  logic [FIRST_W-1:0] first_element_r;
  logic [COUNT_W-1:0] slot_count_r;
  logic               reg_idx;
  logic               wr_en;

  logic [CNT_W-1:0]   live_n;
  logic [31:0]        n_minus1;
  logic [WIDX_W-1:0]  last_word;

  cell_ctl_t          ctl;
  logic [WIDX_W-1:0]  acc_word;
  logic [WIDX_W-1:0]  start_word;
  cell_rsp_t          cell_rsp [NCELLS];
  logic [NCELLS-1:0]  tok_in;
  logic [NCELLS-1:0]  tok_fwd;
  logic [NCELLS-1:0]  tok_wrap;
  cell_rsp_t          chain_rsp;
  logic [WIDX_W-1:0]  found_word;

  assign reg_idx = paddr[ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_FIRST: prdata = DATA_W'(first_element_r);
      REG_COUNT: prdata = DATA_W'(slot_count_r);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_element_r <= FIRST_RESET;
      slot_count_r    <= COUNT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FIRST: first_element_r <= pwdata[FIRST_W-1:0];
        REG_COUNT: slot_count_r    <= pwdata[COUNT_W-1:0];
        default:   first_element_r <= first_element_r;
      endcase
    end
  end

  always_comb begin
    live_n    = (32'(slot_count_r) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(slot_count_r);
    n_minus1  = 32'(live_n) - 32'd1;
    last_word = n_minus1[BIT_W +: WIDX_W];
  end

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign tok_in[k] = |tok_wrap;
    end else begin : g_body
      assign tok_in[k] = tok_fwd[k-1];
    end

    bsa_cell #(
      .WIDX_W (WIDX_W),
      .IDX    (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .acc_word   (acc_word),
      .start_word (start_word),
      .last_word  (last_word),
      .tok_in     (tok_in[k]),
      .rsp        (cell_rsp[k]),
      .tok_fwd    (tok_fwd[k]),
      .tok_wrap   (tok_wrap[k])
    );
  end

  always_comb begin
    chain_rsp  = '0;
    found_word = '0;
    for (int k = 0; k < NCELLS; k++) begin
      chain_rsp = chain_rsp | cell_rsp[k];
      if (cell_rsp[k].found) begin
        found_word = found_word | WIDX_W'(k);
      end
    end
  end

  bsa_ctrl #(
    .WIDX_W (WIDX_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_element          (in_element),
    .out_valid           (out_valid),
    .out_ok              (out_ok),
    .out_granted_element (out_granted_element),
    .first_element       (first_element_r),
    .live_n              (live_n),
    .last_bit            (n_minus1[BIT_W-1:0]),
    .chain_rsp           (chain_rsp),
    .found_word          (found_word),
    .ctl                 (ctl),
    .acc_word            (acc_word),
    .start_word          (start_word)
  );

endmodule

// ===== design/bsa_cell.sv =====
// one cell of the chain: 32 busy bits and the hop of the search token
module bsa_cell #(
  parameter int WIDX_W = 5,
  parameter int IDX    = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bsa_pkg::cell_ctl_t    ctl,
  input  logic [WIDX_W-1:0]     acc_word,
  input  logic [WIDX_W-1:0]     start_word,
  input  logic [WIDX_W-1:0]     last_word,
  input  logic                  tok_in,
  output bsa_pkg::cell_rsp_t    rsp,
  output logic                  tok_fwd,
  output logic                  tok_wrap
);
  import bsa_pkg::*;

  localparam logic [WIDX_W-1:0] MY_IDX = WIDX_W'(IDX);

  logic [WORD_W-1:0] word_r, word_nxt;
  logic              tok_r, tok_nxt;
  logic              fresh_r, fresh_nxt;

  logic              is_start;
  logic              is_last;
  logic              sel;
  logic              final_visit;
  logic              pass;
  logic [WORD_W-1:0] rng_mask;
  logic [WORD_W-1:0] lap_mask;
  logic [WORD_W-1:0] cand;
  logic [BIT_W-1:0]  pick;

  always_comb begin
    is_start = (start_word == MY_IDX);
    is_last  = (last_word == MY_IDX);
    sel      = ctl.access && (acc_word == MY_IDX);

    for (int j = 0; j < WORD_W; j++) begin
      rng_mask[j] = (MY_IDX < last_word) || (is_last && (BIT_W'(j) <= ctl.last_bit));
      if (fresh_r) begin
        lap_mask[j] = (BIT_W'(j) >= ctl.start_bit);
      end else if (is_start) begin
        lap_mask[j] = (BIT_W'(j) < ctl.start_bit);
      end else begin
        lap_mask[j] = 1'b1;
      end
    end

    cand = ~word_r & rng_mask & lap_mask & {WORD_W{tok_r}};

    pick = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pick = BIT_W'(j);
      end
    end

    final_visit = tok_r && !fresh_r && is_start;
    pass        = tok_r && !(|cand) && !final_visit;
    tok_fwd     = pass && !is_last;
    tok_wrap    = pass && is_last;

    rsp.found   = |cand;
    rsp.fail    = final_visit && !(|cand);
    rsp.rd_busy = sel && word_r[ctl.acc_bit];
    rsp.hit_bit = (|cand) ? pick : '0;

    word_nxt = word_r;
    if (sel) begin
      case (ctl.op)
        OP_OCCUPY: word_nxt[ctl.acc_bit] = 1'b1;
        OP_FREE:   word_nxt[ctl.acc_bit] = 1'b0;
        default:   word_nxt = word_r;
      endcase
    end
    if (|cand) begin
      word_nxt[pick] = 1'b1;
    end

    fresh_nxt = ctl.inject && is_start;
    tok_nxt   = fresh_nxt || tok_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r  <= '0;
      tok_r   <= 1'b0;
      fresh_r <= 1'b0;
    end else begin
      word_r  <= word_nxt;
      tok_r   <= tok_nxt;
      fresh_r <= fresh_nxt;
    end
  end

endmodule

// ===== design/bsa_ctrl.sv =====
// sequencer: range check, token launch, result and cursor update
`include "bitmap_slot_allocator_assert.svh"

module bsa_ctrl #(
  parameter int WIDX_W = 5,
  parameter int CNT_W  = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [bsa_pkg::OP_W-1:0]    in_operation,
  input  logic [bsa_pkg::ELEM_W-1:0]  in_element,
  output logic                        out_valid,
  output logic                        out_ok,
  output logic [bsa_pkg::ELEM_W-1:0]  out_granted_element,
  input  logic [bsa_pkg::FIRST_W-1:0] first_element,
  input  logic [CNT_W-1:0]            live_n,
  input  logic [bsa_pkg::BIT_W-1:0]   last_bit,
  input  bsa_pkg::cell_rsp_t          chain_rsp,
  input  logic [WIDX_W-1:0]           found_word,
  output bsa_pkg::cell_ctl_t          ctl,
  output logic [WIDX_W-1:0]           acc_word,
  output logic [WIDX_W-1:0]           start_word
);
  import bsa_pkg::*;

  localparam int SLOT_W = WIDX_W + BIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INJECT,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t              state_r;
  op_t                 op_r;
  logic [ELEM_W-1:0]   elem_r;
  logic [SLOT_W-1:0]   cursor_r;
  logic [SLOT_W-1:0]   start_r;
  logic [SLOT_W-1:0]   hit_r;
  logic                out_valid_r;
  logic                out_ok_r;
  logic [ELEM_W-1:0]   out_granted_r;

  logic [ELEM_W:0]     diff;
  logic                in_range;
  logic [SLOT_W-1:0]   acc_slot;
  logic [SLOT_W-1:0]   start_c;
  logic [31:0]         hit_inc;
  logic [31:0]         grant_sum;
  logic                op_ok;

  always_comb begin
    diff     = {1'b0, elem_r} - {{(ELEM_W + 1 - FIRST_W){1'b0}}, first_element};
    in_range = !diff[ELEM_W] && (32'(diff[ELEM_W-1:0]) < 32'(live_n));
    acc_slot = diff[SLOT_W-1:0];
    start_c  = (32'(cursor_r) < 32'(live_n)) ? cursor_r : '0;
    hit_inc  = 32'(hit_r) + 32'd1;
    grant_sum = 32'(first_element) + 32'(hit_r);

    case (op_r)
      OP_QUERY:  op_ok = !chain_rsp.rd_busy;
      OP_OCCUPY: op_ok = !chain_rsp.rd_busy;
      OP_FREE:   op_ok = chain_rsp.rd_busy;
      default:   op_ok = 1'b0;
    endcase

    ctl.access    = (state_r == S_EXEC) && in_range;
    ctl.op        = op_r;
    ctl.acc_bit   = acc_slot[BIT_W-1:0];
    ctl.inject    = (state_r == S_INJECT) && (live_n != '0);
    ctl.start_bit = start_r[BIT_W-1:0];
    ctl.last_bit  = last_bit;
    acc_word      = acc_slot[SLOT_W-1:BIT_W];
    start_word    = start_r[SLOT_W-1:BIT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cursor_r      <= '0;
      out_valid_r   <= 1'b0;
      out_ok_r      <= 1'b0;
      out_granted_r <= '0;
      op_r          <= OP_QUERY;
      elem_r        <= '0;
      start_r       <= '0;
      hit_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= op_t'(in_operation);
            elem_r  <= in_element;
            start_r <= start_c;
            state_r <= (op_t'(in_operation) == OP_ALLOC) ? S_INJECT : S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid_r   <= 1'b1;
          out_ok_r      <= in_range && op_ok;
          out_granted_r <= '0;
          state_r       <= S_IDLE;
        end
        S_INJECT: begin
          if (live_n == '0) begin
            out_valid_r   <= 1'b1;
            out_ok_r      <= 1'b0;
            out_granted_r <= '0;
            state_r       <= S_IDLE;
          end else begin
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (chain_rsp.found) begin
            hit_r   <= {found_word, chain_rsp.hit_bit};
            state_r <= S_FINISH;
          end else if (chain_rsp.fail) begin
            out_valid_r   <= 1'b1;
            out_ok_r      <= 1'b0;
            out_granted_r <= '0;
            state_r       <= S_IDLE;
          end
        end
        S_FINISH: begin
          out_valid_r   <= 1'b1;
          out_ok_r      <= 1'b1;
          out_granted_r <= grant_sum[ELEM_W-1:0];
          cursor_r      <= (hit_inc >= 32'(live_n)) ? '0 : hit_inc[SLOT_W-1:0];
          state_r       <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_ok              = out_ok_r;
  assign out_granted_element = out_granted_r;

  `BSA_ASSERT_NOW(a_one_outcome, chain_rsp.found, !chain_rsp.fail, "token both hit and failed")
  `BSA_ASSERT_NOW(a_token_in_search, chain_rsp.found || chain_rsp.fail, state_r == S_SEARCH, "token outcome outside search")
  `BSA_ASSERT_NOW(a_beat_ends_job, out_valid_r, state_r == S_IDLE, "result beat while still busy")
  `BSA_ASSERT_NEXT(a_finish_grants, state_r == S_FINISH, out_valid_r && out_ok_r, "allocate hit gave no grant")

endmodule

// ===== bench/bitmap_slot_allocator_tb.sv =====
// self-checking testbench for the next-fit bitmap slot allocator
module bitmap_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsa_pkg::*;

  localparam int SLOTS = 1024;
  localparam logic [ADDR_W-1:0] ADDR_FIRST = {REG_FIRST, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_COUNT = {REG_COUNT, 2'b00};

  typedef struct packed {
    logic              ok;
    logic [ELEM_W-1:0] granted;
  } grant_reply_t;

  typedef struct packed {
    op_t               op;
    logic [ELEM_W-1:0] elem;
    bit                typed;
    grant_reply_t      reply;
  } script_row_t;

  typedef struct {
    int base;
    int span;
    int items;
    int idle_pct;
  } window_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_operation = '0;
  logic [ELEM_W-1:0] in_element = '0;
  logic              out_valid;
  logic              out_ok;
  logic [ELEM_W-1:0] out_granted_element;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bitmap_slot_allocator #(.MAX_SLOTS(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_element(in_element),
    .out_valid(out_valid), .out_ok(out_ok), .out_granted_element(out_granted_element),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // allocator state as the bench sees it
  bit           slot_taken [SLOTS];
  int           scan_from = 0;
  int           base_elem = 0;
  int           span_reg = SLOTS;
  grant_reply_t awaited_replies [$];
  int           errors = 0;

  script_row_t opening_script [19] = '{
    '{OP_QUERY,  17'd0,       1'b1, '{1'b1, 17'd0}},
    '{OP_QUERY,  17'd1023,    1'b1, '{1'b1, 17'd0}},
    '{OP_QUERY,  17'd1024,    1'b1, '{1'b0, 17'd0}},
    '{OP_QUERY,  17'h1FFFF,   1'b1, '{1'b0, 17'd0}},
    '{OP_ALLOC,  17'h1FFFF,   1'b1, '{1'b1, 17'd0}},
    '{OP_ALLOC,  17'd0,       1'b1, '{1'b1, 17'd1}},
    '{OP_OCCUPY, 17'd0,       1'b1, '{1'b0, 17'd0}},
    '{OP_OCCUPY, 17'd1023,    1'b1, '{1'b1, 17'd0}},
    '{OP_OCCUPY, 17'd1024,    1'b1, '{1'b0, 17'd0}},
    '{OP_FREE,   17'd1,       1'b1, '{1'b1, 17'd0}},
    '{OP_FREE,   17'd1,       1'b1, '{1'b0, 17'd0}},
    '{OP_FREE,   17'h1FFFF,   1'b1, '{1'b0, 17'd0}},
    '{OP_QUERY,  17'd0,       1'b1, '{1'b0, 17'd0}},
    '{OP_ALLOC,  17'd0,       1'b0, '{1'b0, 17'd0}},
    '{OP_OCCUPY, 17'd2,       1'b0, '{1'b0, 17'd0}},
    '{OP_FREE,   17'd1023,    1'b1, '{1'b1, 17'd0}},
    '{OP_QUERY,  17'h15555,   1'b1, '{1'b0, 17'd0}},
    '{OP_ALLOC,  17'h0AAAA,   1'b0, '{1'b0, 17'd0}},
    '{OP_FREE,   17'd0,       1'b0, '{1'b0, 17'd0}}
  };

  window_t windows [8] = '{
    '{0,     1024, 140, 0},
    '{65535, 1,    40,  64},
    '{1000,  40,   150, 20},
    '{32768, 100,  120, 0},
    '{32768, 33,   100, 64},
    '{12345, 0,    20,  0},
    '{65535, 2047, 100, 20},
    '{0,     64,   130, 0}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int live_slots();
    return (span_reg > SLOTS) ? SLOTS : span_reg;
  endfunction

  function automatic grant_reply_t predict_grant(op_t op, logic [ELEM_W-1:0] elem);
    grant_reply_t r;
    int n;
    int first_try;
    int s;
    int slot;
    r = '0;
    n = live_slots();
    if (op == OP_ALLOC) begin
      first_try = (scan_from < n) ? scan_from : 0;
      for (int i = 0; i < n && !r.ok; i++) begin
        s = first_try + i;
        if (s >= n) s -= n;
        if (!slot_taken[s]) begin
          slot_taken[s] = 1'b1;
          scan_from = (s + 1 >= n) ? 0 : s + 1;
          r.ok = 1'b1;
          r.granted = ELEM_W'(base_elem + s);
        end
      end
    end else if (int'(elem) >= base_elem && int'(elem) - base_elem < n) begin
      slot = int'(elem) - base_elem;
      case (op)
        OP_QUERY: r.ok = !slot_taken[slot];
        OP_OCCUPY: begin
          r.ok = !slot_taken[slot];
          slot_taken[slot] = 1'b1;
        end
        default: begin
          r.ok = slot_taken[slot];
          slot_taken[slot] = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  // element of some busy slot, or anything when none is busy
  function automatic logic [ELEM_W-1:0] taken_elem();
    int n;
    int s;
    n = live_slots();
    s = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      if (slot_taken[(s + i) % n]) return ELEM_W'(base_elem + (s + i) % n);
    end
    return ELEM_W'($urandom);
  endfunction

  task automatic issue_beat(op_t op, logic [ELEM_W-1:0] elem, bit typed,
                            grant_reply_t typed_reply, int idle_pct);
    grant_reply_t due;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_element <= elem;
    do @(posedge clk); while (busy);
    due = predict_grant(op, elem);
    awaited_replies.push_back(typed ? typed_reply : due);
  endtask

  task automatic random_beat(int idle_pct);
    op_t op;
    logic [ELEM_W-1:0] elem;
    int n;
    int r;
    n = live_slots();
    r = $urandom_range(0, 99);
    op = (r < 20) ? OP_QUERY : (r < 35) ? OP_OCCUPY : (r < 70) ? OP_ALLOC : OP_FREE;
    r = $urandom_range(0, 99);
    if (op == OP_FREE && r < 60 && n > 0) elem = taken_elem();
    else if (r < 75 && n > 0) elem = ELEM_W'(base_elem + $urandom_range(0, n - 1));
    else if (r < 85) elem = $urandom_range(0, 1) ? ELEM_W'(base_elem - 1) : ELEM_W'(base_elem + n);
    else elem = ELEM_W'($urandom);
    issue_beat(op, elem, 1'b0, '0, idle_pct);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_FIRST) base_elem = value & 16'hFFFF;
    else span_reg = value & 11'h7FF;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result beat ok=%0b granted=%0d", $time, out_ok,
                 out_granted_element);
        errors++;
      end else begin
        if (out_ok !== awaited_replies[0].ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, awaited_replies[0].ok, out_ok);
          errors++;
        end
        if (out_granted_element !== awaited_replies[0].granted) begin
          $display("%0t: granted_element expected %0d actual %0d", $time,
                   awaited_replies[0].granted, out_granted_element);
          errors++;
        end
        void'(awaited_replies.pop_front());
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (opening_script[i])
      issue_beat(opening_script[i].op, opening_script[i].elem, opening_script[i].typed,
                 opening_script[i].reply, 0);

    foreach (windows[p]) begin
      drain_replies();
      write_reg(ADDR_FIRST, windows[p].base);
      write_reg(ADDR_COUNT, windows[p].span);
      for (int k = 0; k < windows[p].items; k++) begin
        if (p % 2 == 1 && k == windows[p].items / 2) drain_replies();
        random_beat(windows[p].idle_pct);
      end
    end

    drain_replies();
    repeat (50) @(posedge clk);
    if (errors == 0 && awaited_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
